// ===== rtl/bdq_pkg.sv =====
// Shared types, sizes and codes for the bounded deque.
package bdq_pkg;

   // Ring geometry
   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int WORD_W = 32;

   // Request operation codes
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [2:0] MODE_POP_BACK   = 3'd3;
   localparam logic [2:0] MODE_LIST       = 3'd4;

   // Response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]               mode;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] word;
      logic [1:0]               status;
      logic                     last;
   } rsp_type;

   // Ring store access group
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [WORD_W-1:0] wr_word;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } ring_ctl_type;

   // (base + offset) mod DEPTH, with base < DEPTH and offset <= DEPTH
   function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // (base - 1) mod DEPTH
   function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
      logic [IDX_W-1:0] res;
      if (base == '0) begin
         res = IDX_W'(DEPTH - 1);
      end else begin
         res = base - IDX_W'(1);
      end
      return res;
   endfunction

endpackage

// ===== rtl/bdq_ring.sv =====
// Ring store: one write port and one registered read port.
module bdq_ring
   import bdq_pkg::*;
(
   input  logic              clock,
   input  ring_ctl_type      ctl,
   output logic [WORD_W-1:0] rd_word
);

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_word_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[ctl.wr_addr] <= ctl.wr_word;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_word_ff <= mem_ff[ctl.rd_addr];
      end
   end

   assign rd_word = rd_word_ff;

endmodule

// ===== rtl/bounded_deque_core.sv =====
// Bounded double-ended queue of signed words held in a ring store.
// Push and pop: one beat per cycle while not busy, result registered at the accept edge.
// List: busy while the stored entries are read; entries come front to back one
// per cycle, each through the registered read (one read port).
// Reset (synchronous) clears head index, occupancy, sequencer and strobe;
// the ring store is left as is and needs no clearing pass.
module bounded_deque_core
   import bdq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LIST = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_mem_ff, rsp_mem_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff, rsp_last_in;
   ring_ctl_type      ring_ctl;
   logic [WORD_W-1:0] rd_word;
   logic              full, empty;

   assign full  = (occ_ff == CNT_W'(DEPTH));
   assign empty = (occ_ff == '0);
   assign busy  = (state_ff != ST_IDLE);

   // request decode and list sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      occ_in        = occ_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_mem_in    = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_last_in   = 1'b1;
      ring_ctl      = '0;
      ring_ctl.wr_word = req_data.value;
      ring_ctl.rd_addr = head_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_data.mode)
                  MODE_PUSH_FRONT: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        head_in          = ring_dec(head_ff);
                        ring_ctl.wr_en   = 1'b1;
                        ring_ctl.wr_addr = ring_dec(head_ff);
                        occ_in           = occ_ff + CNT_W'(1);
                     end
                  end
                  MODE_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ring_ctl.wr_en   = 1'b1;
                        ring_ctl.wr_addr = ring_slot(head_ff, occ_ff);
                        occ_in           = occ_ff + CNT_W'(1);
                     end
                  end
                  MODE_POP_FRONT: begin
                     rsp_valid_in = 1'b1;
                     if (empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        ring_ctl.rd_en   = 1'b1;
                        ring_ctl.rd_addr = head_ff;
                        head_in          = ring_slot(head_ff, CNT_W'(1));
                        occ_in           = occ_ff - CNT_W'(1);
                        rsp_mem_in       = 1'b1;
                     end
                  end
                  MODE_POP_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        ring_ctl.rd_en   = 1'b1;
                        ring_ctl.rd_addr = ring_slot(head_ff, occ_ff - CNT_W'(1));
                        occ_in           = occ_ff - CNT_W'(1);
                        rsp_mem_in       = 1'b1;
                     end
                  end
                  MODE_LIST: begin
                     if (empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_LIST;
                        idx_in   = '0;
                     end
                  end
                  default: begin
                     // unused codes: dropped without a response
                  end
               endcase
            end
         end
         ST_LIST: begin
            // one entry read per cycle, response follows the read
            ring_ctl.rd_en   = 1'b1;
            ring_ctl.rd_addr = ring_slot(head_ff, CNT_W'(idx_ff));
            rsp_valid_in     = 1'b1;
            rsp_mem_in       = 1'b1;
            rsp_last_in      = (CNT_W'(idx_ff) + CNT_W'(1) == occ_ff);
            idx_in           = idx_ff + IDX_W'(1);
            if (rsp_last_in) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response side-band and list index
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rsp_mem_ff    <= rsp_mem_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   bdq_ring u_ring (
      .clock   (clock),
      .ctl     (ring_ctl),
      .rd_word (rd_word)
   );

   // response beat: word comes straight from the registered read
   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_data.word   = rsp_mem_ff ? rd_word : '0;
   assign rsp_data.status = rsp_status_ff;
   assign rsp_data.last   = rsp_last_ff;

endmodule
